@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the address decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property that is switched off while reset is asserted.
`define BWAD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked property that is evaluated at every clock edge, reset included.
`define BWAD_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/bwad_pkg.sv @@
// Shared types and constants of the bus window address decoder.
package bwad_pkg;

    // Default number of windows in the table.
    localparam int MAX_WINDOWS_DEF = 16;

    // Field widths.
    localparam int ADDR_W = 64;
    localparam int DATA_W = 64;
    localparam int TGT_W  = 4;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    // Operation codes of an input item.
    localparam logic [OP_W-1:0] OPC_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OPC_READ  = 2'd1;
    localparam logic [OP_W-1:0] OPC_WRITE = 2'd2;
    localparam logic [OP_W-1:0] OPC_QUERY = 2'd3;

    // Status codes of a result item.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOMAP    = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FREE = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the accepted item
        logic add_write;  // append the item to the window table
        logic rd_en;      // read the table entry at the scan index
        logic cmp;        // evaluate the entry that was read
        logic idx_inc;    // advance the scan index
        logic out_load;   // move the result into the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_add;      // the item is an add
        logic full;        // the table was full when the item arrived
        logic skip_scan;   // a query whose range is empty or wraps
        logic count_zero;  // no windows in the table
        logic match;       // the entry just read satisfies the item
        logic last;        // the entry just read is the last one in use
        logic out_free;    // the output register can take a result
    } dp_stat_t;

endpackage

@@ rtl/core/bus_window_address_decoder.sv @@
// An add item, an empty table or an empty or wrapping query range goes from acceptance
// through the decide state to the output state; a scan adds a read and a compare per window examined.
// A new item is accepted only in the idle state, once the last result has entered the output
// register; the scan through the table's single registered read port and a low m_ready delay that.
// Reset (aresetn, synchronous, active low) empties the window table and drops m_valid.
// Top level of the bus window address decoder.
module bus_window_address_decoder #(
    parameter int MAX_WINDOWS = bwad_pkg::MAX_WINDOWS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bwad_pkg::OP_W-1:0]     s_opcode,
    input  logic [bwad_pkg::ADDR_W-1:0]   s_addr,
    input  logic [bwad_pkg::ADDR_W-1:0]   s_length,
    input  logic [bwad_pkg::TGT_W-1:0]    s_target_id,
    input  logic [bwad_pkg::DATA_W-1:0]   s_write_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bwad_pkg::STAT_W-1:0]   m_status,
    output logic [bwad_pkg::TGT_W-1:0]    m_target_index,
    output logic [bwad_pkg::ADDR_W-1:0]   m_offset,
    output logic [bwad_pkg::DATA_W-1:0]   m_data_out
);

    bwad_pkg::ctrl_cmd_t cmd;
    bwad_pkg::dp_stat_t  stat;

    // Sequencer for accept, table scan and result hand-off.
    bwad_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Window table, compare logic and output register.
    bwad_datapath #(
        .MAX_WINDOWS (MAX_WINDOWS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_opcode       (s_opcode),
        .s_addr         (s_addr),
        .s_length       (s_length),
        .s_target_id    (s_target_id),
        .s_write_data   (s_write_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_target_index (m_target_index),
        .m_offset       (m_offset),
        .m_data_out     (m_data_out)
    );

endmodule

@@ rtl/core/bwad_ctrl.sv @@
// Controller state machine of the bus window address decoder.
module bwad_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bwad_pkg::dp_stat_t   stat,
    output bwad_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_READ   = 5'b00100,
        S_CMP    = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (stat.op_add) begin
                    cmd.add_write = !stat.full;
                    state_next    = S_OUT;
                end else if (stat.skip_scan || stat.count_zero) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP: begin
                cmd.cmp = 1'b1;
                if (stat.match || stat.last) begin
                    state_next = S_OUT;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/bwad_datapath.sv @@
// Datapath of the bus window address decoder: item registers, window table and result.
`include "assert_macros.svh"

module bwad_datapath #(
    parameter int MAX_WINDOWS = bwad_pkg::MAX_WINDOWS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bwad_pkg::ctrl_cmd_t           cmd,
    output bwad_pkg::dp_stat_t            stat,
    input  logic [bwad_pkg::OP_W-1:0]     s_opcode,
    input  logic [bwad_pkg::ADDR_W-1:0]   s_addr,
    input  logic [bwad_pkg::ADDR_W-1:0]   s_length,
    input  logic [bwad_pkg::TGT_W-1:0]    s_target_id,
    input  logic [bwad_pkg::DATA_W-1:0]   s_write_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bwad_pkg::STAT_W-1:0]   m_status,
    output logic [bwad_pkg::TGT_W-1:0]    m_target_index,
    output logic [bwad_pkg::ADDR_W-1:0]   m_offset,
    output logic [bwad_pkg::DATA_W-1:0]   m_data_out
);

    localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOWS + 1);
    localparam int AW    = bwad_pkg::ADDR_W;

    // Captured item.
    logic [bwad_pkg::OP_W-1:0]   op_reg;
    logic [AW-1:0]               addr_reg;
    logic [bwad_pkg::TGT_W-1:0]  tid_reg;
    logic [bwad_pkg::DATA_W-1:0] wdata_reg;
    logic [AW-1:0]               len_reg;
    logic [AW:0]                 end_reg;
    logic                        full_reg;
    logic                        bad_reg;
    logic [AW:0]                 item_end;

    // Window table and its read port.
    logic [AW-1:0]               base_mem [MAX_WINDOWS];
    logic [AW-1:0]               size_mem [MAX_WINDOWS];
    logic [bwad_pkg::TGT_W-1:0]  tgt_mem  [MAX_WINDOWS];
    logic [AW-1:0]               rd_base_reg;
    logic [AW-1:0]               rd_size_reg;
    logic [bwad_pkg::TGT_W-1:0]  rd_tgt_reg;

    // Control counters and hit capture.
    logic [CNT_W-1:0]            count_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic                        hit_reg;
    logic [bwad_pkg::TGT_W-1:0]  hit_tgt_reg;
    logic [AW-1:0]               hit_off_reg;

    // Output register.
    logic                        m_valid_reg;
    logic [bwad_pkg::STAT_W-1:0] m_status_reg;
    logic [bwad_pkg::TGT_W-1:0]  m_tgt_reg;
    logic [AW-1:0]               m_off_reg;
    logic [bwad_pkg::DATA_W-1:0] m_dout_reg;

    // Comparison and result logic.
    logic [AW:0]                 ent_end;
    logic                        acc_match;
    logic                        qry_match;
    logic                        is_query;
    logic [bwad_pkg::STAT_W-1:0] res_status;
    logic [bwad_pkg::TGT_W-1:0]  res_tgt;
    logic [AW-1:0]               res_off;
    logic [bwad_pkg::DATA_W-1:0] res_dout;

    // End of the incoming range, formed in 65 bits so it never wraps.
    assign item_end = {1'b0, s_addr} + {1'b0, s_length};

    // Item capture.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_opcode;
            addr_reg  <= s_addr;
            len_reg   <= s_length;
            tid_reg   <= s_target_id;
            wdata_reg <= s_write_data;
            end_reg   <= item_end;
            full_reg  <= (count_reg >= CNT_W'(MAX_WINDOWS));
            bad_reg   <= (s_length == '0) || item_end[AW];
        end
    end

    // Table write on add, registered read during the scan.
    always_ff @(posedge aclk) begin
        if (cmd.add_write) begin
            base_mem[count_reg[IDX_W-1:0]] <= addr_reg;
            size_mem[count_reg[IDX_W-1:0]] <= len_reg;
            tgt_mem[count_reg[IDX_W-1:0]]  <= tid_reg;
        end
        if (cmd.rd_en) begin
            rd_base_reg <= base_mem[idx_reg];
            rd_size_reg <= size_mem[idx_reg];
            rd_tgt_reg  <= tgt_mem[idx_reg];
        end
    end

    // Window count and scan index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
        end else begin
            if (cmd.add_write) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.load) begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
            end else begin
                if (cmd.idx_inc) begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                if (cmd.cmp && stat.match) begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    // Entry compare: containment for accesses, overlap for queries.
    assign ent_end   = {1'b0, rd_base_reg} + {1'b0, rd_size_reg};
    assign acc_match = (addr_reg >= rd_base_reg) && (end_reg <= ent_end);
    assign qry_match = ({1'b0, addr_reg} < ent_end) && ({1'b0, rd_base_reg} < end_reg);
    assign is_query  = (op_reg == bwad_pkg::OPC_QUERY);

    // Hit payload capture.
    always_ff @(posedge aclk) begin
        if (cmd.cmp && stat.match) begin
            hit_tgt_reg <= rd_tgt_reg;
            hit_off_reg <= addr_reg - rd_base_reg;
        end
    end

    // Status toward the controller.
    always_comb begin
        stat.op_add     = (op_reg == bwad_pkg::OPC_ADD);
        stat.full       = full_reg;
        stat.skip_scan  = is_query && bad_reg;
        stat.count_zero = (count_reg == '0);
        stat.match      = is_query ? qry_match : acc_match;
        stat.last       = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
        stat.out_free   = !m_valid_reg || m_ready;
    end

    // Result of the item.
    always_comb begin
        res_status = bwad_pkg::ST_OK;
        res_tgt    = '0;
        res_off    = '0;
        res_dout   = '0;
        case (op_reg)
            bwad_pkg::OPC_ADD: begin
                res_status = full_reg ? bwad_pkg::ST_FULL : bwad_pkg::ST_OK;
            end
            bwad_pkg::OPC_QUERY: begin
                res_status = (bad_reg || hit_reg) ? bwad_pkg::ST_NOT_FREE : bwad_pkg::ST_OK;
            end
            default: begin
                if (hit_reg) begin
                    res_tgt = hit_tgt_reg;
                    res_off = hit_off_reg;
                    if (op_reg == bwad_pkg::OPC_WRITE) begin
                        res_dout = wdata_reg;
                    end
                end else begin
                    res_status = bwad_pkg::ST_NOMAP;
                end
            end
        endcase
    end

    // Output register: holds a result until it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg <= res_status;
            m_tgt_reg    <= res_tgt;
            m_off_reg    <= res_off;
            m_dout_reg   <= res_dout;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_target_index = m_tgt_reg;
    assign m_offset       = m_off_reg;
    assign m_data_out     = m_dout_reg;

    // The table never holds more windows than it has room for.
    `BWAD_ASSERT(a_count_max, aclk, aresetn, count_reg <= CNT_W'(MAX_WINDOWS), "window count above table size")
    // Each append grows the count by exactly one.
    `BWAD_ASSERT(a_add_inc, aclk, aresetn, cmd.add_write |=> count_reg == $past(count_reg) + CNT_W'(1), "append did not bump count")
    // A new result never overwrites one that is still waiting.
    `BWAD_ASSERT(a_out_free, aclk, aresetn, cmd.out_load |-> (!m_valid_reg || m_ready), "result overwritten while stalled")
    // Reset empties the table and the output register.
    `BWAD_ASSERT_NR(a_reset_clear, aclk, !aresetn |=> (count_reg == '0 && !m_valid_reg), "reset did not clear state")

endmodule
